// ===== src/rtdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtdt_pkg;

	localparam int DEF_TABLE_DEPTH   = 64;
	localparam int DEF_MAX_UID_BYTES = 10;

	localparam int IDX_W         = 6;
	localparam int ENTRY_COUNT_W = 7;
	localparam int COUNTER_W     = 19;
	localparam int COUNTER_WRAP  = 500000;
	localparam int ISO15693_UID_BYTES = 8;

	typedef enum logic [1:0] {
		ACT_CLEAR     = 2'd0,
		ACT_ISO15693  = 2'd1,
		ACT_ISO14443A = 2'd2,
		ACT_READ      = 2'd3
	} action_t;

	typedef struct packed {
		logic [63:0]          uid_low;
		logic [15:0]          uid_high;
		logic [3:0]           uid_len;
		logic [7:0]           antenna;
		logic [31:0]          tag_type;
		logic [31:0]          air_protocol;
		logic [15:0]          rssi;
		logic [COUNTER_W-1:0] counter;
	} entry_t;

	// travels down the row of cells, one cell per cycle while the row is not held
	typedef struct packed {
		logic             active;
		action_t          op;
		logic             done;
		logic             hit;
		logic [IDX_W-1:0] index;
		entry_t           e;
	} probe_t;

endpackage

`default_nettype wire

// ===== src/rtdt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtdt_cell #(
	parameter int CELL_INDEX = 0,
	parameter int CNT_W      = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic [CNT_W-1:0] count,
	input  wire rtdt_pkg::probe_t probe_i,
	output rtdt_pkg::probe_t      probe_o
);
	import rtdt_pkg::*;

	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(CELL_INDEX);

	entry_t               entry_q;
	probe_t               probe_q;
	probe_t               probe_d;
	logic                 occupied;
	logic                 is_report;
	logic                 key_hit;
	logic                 do_hit;
	logic                 do_append;
	logic                 do_read;
	logic [COUNTER_W-1:0] cnt_inc;

	always_comb begin
		occupied  = MY_IDX < CMP_W'(count);
		is_report = (probe_i.op == ACT_ISO15693) || (probe_i.op == ACT_ISO14443A);
		key_hit   = (entry_q.uid_low == probe_i.e.uid_low) &&
		            (entry_q.uid_high == probe_i.e.uid_high) &&
		            (entry_q.uid_len == probe_i.e.uid_len) &&
		            (entry_q.antenna == probe_i.e.antenna);
		do_hit    = probe_i.active && is_report && !probe_i.done && occupied && key_hit;
		do_append = probe_i.active && is_report && !probe_i.done &&
		            (MY_IDX == CMP_W'(count));
		do_read   = probe_i.active && (probe_i.op == ACT_READ) && occupied &&
		            (MY_IDX == CMP_W'(probe_i.index));
		cnt_inc   = (entry_q.counter == COUNTER_W'(COUNTER_WRAP - 1)) ?
		            COUNTER_W'(1) : entry_q.counter + COUNTER_W'(1);
	end

	always_comb begin
		probe_d = probe_i;
		if (do_hit) begin
			probe_d.done           = 1'b1;
			probe_d.hit            = 1'b1;
			probe_d.index          = IDX_W'(CELL_INDEX);
			probe_d.e.tag_type     = entry_q.tag_type;
			probe_d.e.air_protocol = entry_q.air_protocol;
			probe_d.e.counter      = cnt_inc;
			if (probe_i.op == ACT_ISO14443A) begin
				probe_d.e.rssi = entry_q.rssi;
			end
		end else if (do_append) begin
			probe_d.done  = 1'b1;
			probe_d.index = IDX_W'(CELL_INDEX);
		end else if (do_read) begin
			probe_d.done = 1'b1;
			probe_d.e    = entry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (do_hit) begin
				entry_q.counter <= cnt_inc;
				entry_q.rssi    <= probe_d.e.rssi;
			end else if (do_append) begin
				entry_q <= probe_i.e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else if (adv) begin
			probe_q <= probe_d;
		end
	end

	assign probe_o = probe_q;

endmodule

`default_nettype wire

// ===== src/rfid_tag_dedup_table.sv =====
// Tag de-duplication table for one inventory round. Each transfer on the
// input channel is one action: clear, ISO15693 report, ISO14443A report or
// read entry; each gives exactly one result transfer. Entries live in a row
// of TABLE_DEPTH cells and an action walks down that row one cell per cycle
// while the row is not held, passing one register per cell before its result
// is registered at the output; the next item is not taken until that result
// is registered. A result that waits at the output while the following item
// reaches the end of the row holds the row until it is taken. Table contents
// are undefined after reset; only the entry count, the busy and output-valid
// flags and the probe registers of the row are cleared.
`timescale 1ns / 1ps
`default_nettype none

module rfid_tag_dedup_table #(
	parameter int TABLE_DEPTH   = rtdt_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_UID_BYTES = rtdt_pkg::DEF_MAX_UID_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [63:0] uid_low,
	input  wire logic [15:0] uid_high,
	input  wire logic [3:0]  uid_length,
	input  wire logic [7:0]  antenna,
	input  wire logic [31:0] tag_type,
	input  wire logic [31:0] air_protocol,
	input  wire logic [15:0] signal_strength,
	input  wire logic [5:0]  read_index,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [5:0]       entry_index,
	output logic             was_present,
	output logic             dropped,
	output logic [18:0]      hit_count,
	output logic [6:0]       entry_count,
	output logic [63:0]      out_uid_low,
	output logic [15:0]      out_uid_high,
	output logic [3:0]       out_uid_length,
	output logic [7:0]       out_antenna,
	output logic [31:0]      out_tag_type,
	output logic [31:0]      out_air_protocol,
	output logic [15:0]      out_signal_strength
);
	import rtdt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	function automatic logic [63:0] low_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (len > 4'(b)) m[63-8*b -: 8] = 8'hFF;
		end
		return m;
	endfunction

	function automatic logic [15:0] high_mask(input logic [3:0] len);
		logic [15:0] m;
		m = '0;
		if (len >= 4'd9)  m[15:8] = 8'hFF;
		if (len >= 4'd10) m[7:0]  = 8'hFF;
		return m;
	endfunction

	probe_t                 probe [TABLE_DEPTH+1];
	probe_t                 inj;
	probe_t                 tail;
	action_t                op_in;
	logic [3:0]             len;
	logic                   adv;
	logic                   capture;
	logic                   tail_report;
	logic                   busy_q;
	logic                   out_valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic [IDX_W-1:0]       index_q;
	logic                   present_q;
	logic                   dropped_q;
	logic [CNT_W-1:0]       count_out_q;
	entry_t                 out_e_q;

	always_comb begin
		op_in = action_t'(action);
		if (op_in == ACT_ISO15693) begin
			len = 4'(ISO15693_UID_BYTES);
		end else if (uid_length > 4'(MAX_UID_BYTES)) begin
			len = 4'(MAX_UID_BYTES);
		end else begin
			len = uid_length;
		end
		inj                = '0;
		inj.active         = in_valid && !busy_q;
		inj.op             = op_in;
		inj.index          = (op_in == ACT_READ) ? read_index : '0;
		inj.e.uid_low      = uid_low & low_mask(len);
		inj.e.uid_high     = uid_high & high_mask(len);
		inj.e.uid_len      = len;
		inj.e.antenna      = antenna;
		inj.e.tag_type     = tag_type;
		inj.e.air_protocol = air_protocol;
		inj.e.rssi         = (op_in == ACT_ISO15693) ? signal_strength : 16'd0;
		inj.e.counter      = COUNTER_W'(1);
	end

	assign probe[0] = inj;
	assign tail     = probe[TABLE_DEPTH];
	assign adv      = !(tail.active && out_valid_q && out_stall);
	assign capture  = adv && tail.active;
	assign in_stall = busy_q;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		rtdt_cell #(
			.CELL_INDEX(g),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.count  (count_q),
			.probe_i(probe[g]),
			.probe_o(probe[g+1])
		);
	end

	always_comb begin
		tail_report = (tail.op == ACT_ISO15693) || (tail.op == ACT_ISO14443A);
		count_d     = count_q;
		if (tail.op == ACT_CLEAR) begin
			count_d = '0;
		end else if (tail_report && tail.done && !tail.hit) begin
			count_d = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (capture) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				count_q     <= count_d;
			end else begin
				if (inj.active) busy_q <= 1'b1;
				if (!out_stall) out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			index_q     <= tail.index;
			present_q   <= tail.hit;
			dropped_q   <= tail_report && !tail.done;
			count_out_q <= count_d;
			out_e_q     <= tail.done ? tail.e : '0;
		end
	end

	assign out_valid           = out_valid_q;
	assign entry_index         = index_q;
	assign was_present         = present_q;
	assign dropped             = dropped_q;
	assign entry_count         = ENTRY_COUNT_W'(count_out_q);
	assign hit_count           = out_e_q.counter;
	assign out_uid_low         = out_e_q.uid_low;
	assign out_uid_high        = out_e_q.uid_high;
	assign out_uid_length      = out_e_q.uid_len;
	assign out_antenna         = out_e_q.antenna;
	assign out_tag_type        = out_e_q.tag_type;
	assign out_air_protocol    = out_e_q.air_protocol;
	assign out_signal_strength = out_e_q.rssi;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |-> busy_q)
		else $error("probe at end of row while idle");

	a_hit_or_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(present_q && dropped_q))
		else $error("result flagged both hit and dropped");

	a_one_append: assert property (@(posedge clk) disable iff (!arst_n)
		capture && tail.op != ACT_CLEAR |=> count_q == $past(count_q) ||
		count_q == $past(count_q) + CNT_W'(1))
		else $error("entry count moved by more than one");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import rtdt_pkg::*;

	localparam int DEPTH   = DEF_TABLE_DEPTH;
	localparam int MAX_UID = DEF_MAX_UID_BYTES;
	localparam int N_PLAN  = 21;

	typedef struct packed {
		action_t     act;
		logic [63:0] uid_low;
		logic [15:0] uid_high;
		logic [3:0]  uid_len;
		logic [7:0]  antenna;
		logic [31:0] tag_type;
		logic [31:0] air_protocol;
		logic [15:0] rssi;
		logic [5:0]  read_index;
	} item_t;

	typedef struct packed {
		logic [5:0] index;
		logic       present;
		logic       lost;
		logic [6:0] count;
		entry_t     e;
	} result_t;

	typedef struct packed {
		item_t   it;
		logic    typed;
		result_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = '0;
	logic [63:0] uid_low = '0;
	logic [15:0] uid_high = '0;
	logic [3:0]  uid_length = '0;
	logic [7:0]  antenna = '0;
	logic [31:0] tag_type = '0;
	logic [31:0] air_protocol = '0;
	logic [15:0] signal_strength = '0;
	logic [5:0]  read_index = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  entry_index;
	logic        was_present;
	logic        dropped;
	logic [18:0] hit_count;
	logic [6:0]  entry_count;
	logic [63:0] out_uid_low;
	logic [15:0] out_uid_high;
	logic [3:0]  out_uid_length;
	logic [7:0]  out_antenna;
	logic [31:0] out_tag_type;
	logic [31:0] out_air_protocol;
	logic [15:0] out_signal_strength;

	entry_t  known_tags [DEPTH];
	int      known_count = 0;
	result_t awaited_results [$];
	int      errors = 0;
	int      sent = 0;
	int      stall_left = 0;
	bit      calm_in = 1'b0;
	bit      calm_out = 1'b0;

	plan_row_t plan [N_PLAN] = '{
		'{'{ACT_READ, 64'h0, 16'h0, 4'd0, 8'd0, 32'h0, 32'h0, 16'h0, 6'd0}, 1'b1, '0},
		'{'{ACT_READ, '1, '1, 4'hf, 8'hff, '1, '1, '1, 6'd63}, 1'b1,
			'{6'd63, 1'b0, 1'b0, 7'd0, '0}},
		'{'{ACT_CLEAR, '1, '1, 4'hf, 8'hff, '1, '1, '1, 6'd63}, 1'b1, '0},
		'{'{ACT_ISO15693, '1, 16'hffff, 4'd0, 8'hff, '1, '1, 16'hffff, 6'd0}, 1'b1,
			'{6'd0, 1'b0, 1'b0, 7'd1,
			'{64'hffff_ffff_ffff_ffff, 16'h0, 4'd8, 8'hff, 32'hffff_ffff, 32'hffff_ffff,
			16'hffff, 19'd1}}},
		'{'{ACT_ISO15693, '1, 16'h0, 4'd15, 8'hff, 32'h0, 32'h0, 16'h0, 6'd5}, 1'b0, '0},
		'{'{ACT_ISO14443A, '1, 16'hffff, 4'd10, 8'h0, 32'h0, 32'h0, 16'h1234, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO14443A, '1, 16'hffff, 4'd15, 8'h0, '1, '1, 16'h4321, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO14443A, '1, 16'hffff, 4'd8, 8'hff, 32'h5, 32'h6, 16'h5555, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO15693, '1, 16'h0, 4'd8, 8'hfe, 32'h1, 32'h2, 16'h8000, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO14443A, 64'h0123_4567_89ab_cdef, 16'h0, 4'd0, 8'd7, 32'h3, 32'h4,
			16'h1, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO14443A, 64'hfedc_ba98_7654_3210, 16'hbeef, 4'd0, 8'd7, 32'h3, 32'h4,
			16'h2, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO14443A, 64'h1122_3344_5566_7788, 16'habcd, 4'd9, 8'd1, 32'h7, 32'h8,
			16'h3, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO14443A, 64'h1122_3344_5566_7788, 16'habff, 4'd9, 8'd1, 32'h9, 32'ha,
			16'h4, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO14443A, 64'h0123_4567_89ab_cdef, 16'hffff, 4'd3, 8'd2, 32'hb, 32'hc,
			16'h5, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO14443A, 64'h8000_0000_0000_0001, 16'h0, 4'd1, 8'd0, 32'hd, 32'he,
			16'h6, 6'd0}, 1'b0, '0},
		'{'{ACT_ISO14443A, 64'h0, 16'h0, 4'd10, 8'd0, 32'h0, 32'h0, 16'h7, 6'd0}, 1'b0, '0},
		'{'{ACT_READ, 64'h0, 16'h0, 4'd0, 8'd0, 32'h0, 32'h0, 16'h0, 6'd2}, 1'b0, '0},
		'{'{ACT_READ, 64'h0, 16'h0, 4'd0, 8'd0, 32'h0, 32'h0, 16'h0, 6'd8}, 1'b0, '0},
		'{'{ACT_CLEAR, 64'h0, 16'h0, 4'd0, 8'd0, 32'h0, 32'h0, 16'h0, 6'd0}, 1'b1, '0},
		'{'{ACT_READ, 64'h0, 16'h0, 4'd0, 8'd0, 32'h0, 32'h0, 16'h0, 6'd0}, 1'b1, '0},
		'{'{ACT_ISO15693, 64'h0, 16'h0, 4'd0, 8'd0, 32'h0, 32'h0, 16'h0, 6'd0}, 1'b0, '0}
	};

	rfid_tag_dedup_table i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.action              (action),
		.uid_low             (uid_low),
		.uid_high            (uid_high),
		.uid_length          (uid_length),
		.antenna             (antenna),
		.tag_type            (tag_type),
		.air_protocol        (air_protocol),
		.signal_strength     (signal_strength),
		.read_index          (read_index),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.entry_index         (entry_index),
		.was_present         (was_present),
		.dropped             (dropped),
		.hit_count           (hit_count),
		.entry_count         (entry_count),
		.out_uid_low         (out_uid_low),
		.out_uid_high        (out_uid_high),
		.out_uid_length      (out_uid_length),
		.out_antenna         (out_antenna),
		.out_tag_type        (out_tag_type),
		.out_air_protocol    (out_air_protocol),
		.out_signal_strength (out_signal_strength)
	);

	always #1 clk = ~clk;

	function automatic void uid_masks(input int len, output logic [63:0] lo_m,
			output logic [15:0] hi_m);
		lo_m = (len == 0) ? 64'h0 : (len >= 8) ? ~64'h0 : ~64'h0 << (64 - 8 * len);
		hi_m = (len >= 10) ? 16'hffff : (len == 9) ? 16'hff00 : 16'h0;
	endfunction

	// table update and the result it produces
	function automatic result_t apply_action(item_t it);
		result_t     r;
		int          len;
		int          n;
		int          c;
		logic [63:0] lo_m;
		logic [15:0] hi_m;
		logic [63:0] lo;
		logic [15:0] hi;
		r = '0;
		case (it.act)
			ACT_CLEAR: begin
				known_count = 0;
			end
			ACT_READ: begin
				r.index = it.read_index;
				if (int'(it.read_index) < known_count)
					r.e = known_tags[it.read_index];
			end
			default: begin
				if (it.act == ACT_ISO15693)
					len = ISO15693_UID_BYTES;
				else
					len = (it.uid_len > MAX_UID) ? MAX_UID : int'(it.uid_len);
				uid_masks(len, lo_m, hi_m);
				lo = it.uid_low & lo_m;
				hi = it.uid_high & hi_m;
				n = -1;
				for (int i = 0; i < known_count; i++) begin
					if (n < 0 && known_tags[i].uid_low == lo && known_tags[i].uid_high == hi &&
							known_tags[i].uid_len == 4'(len) &&
							known_tags[i].antenna == it.antenna)
						n = i;
				end
				if (n >= 0) begin
					c = int'(known_tags[n].counter) + 1;
					if (c >= COUNTER_WRAP)
						c = 1;
					known_tags[n].counter = COUNTER_W'(c);
					if (it.act == ACT_ISO15693)
						known_tags[n].rssi = it.rssi;
					r.index = 6'(n);
					r.present = 1'b1;
					r.e = known_tags[n];
				end else if (known_count >= DEPTH) begin
					r.lost = 1'b1;
				end else begin
					known_tags[known_count] = '{lo, hi, 4'(len), it.antenna, it.tag_type,
						it.air_protocol, (it.act == ACT_ISO15693) ? it.rssi : 16'h0, 19'd1};
					r.index = 6'(known_count);
					r.e = known_tags[known_count];
					known_count++;
				end
			end
		endcase
		r.count = 7'(known_count);
		return r;
	endfunction

	function automatic item_t any_item();
		item_t it;
		it.act = action_t'($urandom_range(0, 3));
		it.uid_low = {$urandom, $urandom};
		it.uid_high = 16'($urandom);
		it.uid_len = 4'($urandom);
		it.antenna = 8'($urandom);
		it.tag_type = $urandom;
		it.air_protocol = $urandom;
		it.rssi = 16'($urandom);
		it.read_index = 6'($urandom);
		return it;
	endfunction

	function automatic item_t fresh_key(int min_len);
		item_t it;
		it = any_item();
		it.act = $urandom_range(0, 1) ? ACT_ISO15693 : ACT_ISO14443A;
		it.uid_len = 4'($urandom_range(min_len, MAX_UID));
		if ($urandom_range(0, 1))
			it.antenna = 8'($urandom_range(0, 3));
		return it;
	endfunction

	// same key, fresh payload and fresh bits outside the UID length
	function automatic item_t rerun(item_t key);
		item_t       it;
		int          len;
		logic [63:0] lo_m;
		logic [15:0] hi_m;
		it = any_item();
		it.act = key.act;
		it.antenna = key.antenna;
		len = (key.act == ACT_ISO15693) ? ISO15693_UID_BYTES : int'(key.uid_len);
		uid_masks(len, lo_m, hi_m);
		it.uid_low = (key.uid_low & lo_m) | (it.uid_low & ~lo_m);
		it.uid_high = (key.uid_high & hi_m) | (it.uid_high & ~hi_m);
		if (key.act == ACT_ISO14443A)
			it.uid_len = (len == MAX_UID) ? 4'($urandom_range(MAX_UID, 15)) : key.uid_len;
		return it;
	endfunction

	task automatic send_item(item_t it, bit typed = 1'b0, result_t want = '0);
		int      gap;
		result_t r;
		if ($urandom_range(0, 39) == 0)
			calm_in = ~calm_in;
		gap = calm_in ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		action = it.act;
		uid_low = it.uid_low;
		uid_high = it.uid_high;
		uid_length = it.uid_len;
		antenna = it.antenna;
		tag_type = it.tag_type;
		air_protocol = it.air_protocol;
		signal_strength = it.rssi;
		read_index = it.read_index;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = apply_action(it);
		awaited_results.insert(awaited_results.size(), typed ? want : r);
		sent++;
		@(negedge clk);
	endtask

	// fill: enough distinct keys to overflow the table
	task automatic inventory_round(bit fill);
		item_t key;
		item_t pool [8];
		item_t it;
		int    n_pool;
		int    n_items;
		int    pick;
		it = any_item();
		it.act = ACT_CLEAR;
		send_item(it);
		n_pool = $urandom_range(1, 8);
		for (int j = 0; j < 8; j++)
			pool[j] = fresh_key(0);
		n_items = fill ? DEPTH + 16 : $urandom_range(4, 30);
		for (int j = 0; j < n_items; j++) begin
			pick = $urandom_range(0, 15);
			if (fill && j < DEPTH + 4) begin
				key = fresh_key(4);
				if (j < 8)
					pool[j] = key;
				n_pool = 8;
				send_item(key);
			end else if (pick < 2) begin
				it = any_item();
				it.act = ACT_READ;
				send_item(it);
			end else if (pick == 2) begin
				send_item(any_item());
			end else if (pick < 5) begin
				send_item(fresh_key(0));
			end else if (pick == 5) begin
				it = rerun(pool[$urandom_range(0, n_pool - 1)]);
				it.antenna = it.antenna ^ 8'(1 << $urandom_range(0, 7));
				send_item(it);
			end else begin
				send_item(rerun(pool[$urandom_range(0, n_pool - 1)]));
			end
		end
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("mismatch %s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.index = entry_index;
			got.present = was_present;
			got.lost = dropped;
			got.count = entry_count;
			got.e = '{out_uid_low, out_uid_high, out_uid_length, out_antenna, out_tag_type,
				out_air_protocol, out_signal_strength, hit_count};
			if (awaited_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transfer, entry_index %0d", entry_index);
			end else begin
				want = awaited_results.pop_front();
				check_field("entry_index", 64'(want.index), 64'(got.index));
				check_field("was_present", 64'(want.present), 64'(got.present));
				check_field("dropped", 64'(want.lost), 64'(got.lost));
				check_field("hit_count", 64'(want.e.counter), 64'(got.e.counter));
				check_field("entry_count", 64'(want.count), 64'(got.count));
				check_field("out_uid_low", want.e.uid_low, got.e.uid_low);
				check_field("out_uid_high", 64'(want.e.uid_high), 64'(got.e.uid_high));
				check_field("out_uid_length", 64'(want.e.uid_len), 64'(got.e.uid_len));
				check_field("out_antenna", 64'(want.e.antenna), 64'(got.e.antenna));
				check_field("out_tag_type", 64'(want.e.tag_type), 64'(got.e.tag_type));
				check_field("out_air_protocol", 64'(want.e.air_protocol),
					64'(got.e.air_protocol));
				check_field("out_signal_strength", 64'(want.e.rssi), 64'(got.e.rssi));
			end
			if ($urandom_range(0, 49) == 0)
				calm_out = ~calm_out;
			stall_left = calm_out ? 0 : $urandom_range(0, 18);
		end
	end

	// hold each result for its drawn count; toggle freely while nothing is offered
	always @(negedge clk) begin
		if (out_valid === 1'b1 && stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (out_valid === 1'b1) begin
			out_stall = 1'b0;
		end else begin
			out_stall = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int fills;
		int k;
		fills = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (k = 0; k < N_PLAN; k++)
			send_item(plan[k].it, plan[k].typed, plan[k].want);
		while (sent < N_PLAN + 500) begin
			if ((fills == 0 && sent > 150) || ($urandom_range(0, 9) == 0 && fills < 3)) begin
				inventory_round(1'b1);
				fills++;
			end else begin
				inventory_round(1'b0);
			end
		end
		in_valid = 1'b0;
		for (k = 0; k < 20000 && awaited_results.size() != 0; k++)
			@(posedge clk);
		repeat (2 * DEPTH) @(posedge clk);
		if (awaited_results.size() != 0) begin
			errors += awaited_results.size();
			$display("%0d results never arrived", awaited_results.size());
		end
		if (errors == 0)
			$display("rfid_tag_dedup_table test passed");
		else
			$display("rfid_tag_dedup_table test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout");
		$display("rfid_tag_dedup_table test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rtdt_pkg.sv
src/rtdt_cell.sv
src/rfid_tag_dedup_table.sv
bench/testbench.sv
